// ===== rtl/core/sba_pkg.sv =====
// Package for the sector bitmap allocator: sizes, command codes and the
// structures passed between the sequencer and the word unit. No dependencies.
package sba_pkg;

  localparam int SECTORS      = 4096;
  localparam int SECTOR_BYTES = 512;

  localparam int IDX_W  = 12;
  localparam int SIZE_W = 21;
  localparam int CMD_W  = 3;
  localparam int RUN_W  = SIZE_W + 1;

  localparam int WORD_BITS = 64;
  localparam int WORDS     = SECTORS / WORD_BITS;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WADDR_W   = $clog2(WORDS);
  localparam int LOG_SB    = $clog2(SECTOR_BYTES);

  localparam logic [IDX_W-1:0] LAST_SECTOR = IDX_W'(SECTORS - 1);

  localparam logic [CMD_W-1:0] CMD_SET   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TEST  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND0 = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FINDS = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RUN   = 3'd5;

  typedef struct packed {
    logic             op_clear;
    logic [BIT_W-1:0] lo;
    logic [BIT_W-1:0] hi;
  } sba_alu_op_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] new_word;
    logic                 hit_any;
    logic                 free_any;
    logic [BIT_W-1:0]     free_pos;
  } sba_alu_res_t;

endpackage

// ===== rtl/core/sba_if.sv =====
// Valid/ready channel interfaces for the command and result beats of the
// sector bitmap allocator. Depends on sba_pkg.
interface sba_in_if;
  import sba_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0]  command;
  logic [IDX_W-1:0]  sector_index;
  logic [SIZE_W-1:0] size_bytes;

  modport source (output valid, command, sector_index, size_bytes, input ready);
  modport sink   (input valid, command, sector_index, size_bytes, output ready);
endinterface

interface sba_out_if;
  import sba_pkg::*;

  logic             valid;
  logic             ready;
  logic             bit_value;
  logic             found;
  logic [IDX_W-1:0] free_sector;
  logic             range_error;

  modport source (output valid, bit_value, found, free_sector, range_error, input ready);
  modport sink   (input valid, bit_value, found, free_sector, range_error, output ready);
endinterface

// ===== rtl/core/sba_bitmap_mem.sv =====
// Bitmap storage: one word of sector bits per row, registered read, and a
// valid bit per row so that unwritten rows read as free. Depends on sba_pkg.
module sba_bitmap_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [sba_pkg::WADDR_W-1:0]   rd_addr,
  input  logic                          wr_en,
  input  logic [sba_pkg::WADDR_W-1:0]   wr_addr,
  input  logic [sba_pkg::WORD_BITS-1:0] wr_data,
  output logic [sba_pkg::WORD_BITS-1:0] rd_data
);
  import sba_pkg::*;

  logic [WORD_BITS-1:0] mem_r [WORDS];
  logic [WORDS-1:0]     row_vld_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== rtl/core/sba_word_alu.sv =====
// Shared word unit: builds the bit mask for a span of one bitmap word, sets or
// clears it, tests it and finds the lowest free bit. Depends on sba_pkg.
module sba_word_alu (
  input  logic [sba_pkg::WORD_BITS-1:0] word,
  input  sba_pkg::sba_alu_op_t          op,
  output sba_pkg::sba_alu_res_t         res
);
  import sba_pkg::*;

  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [BIT_W-1:0]     pos;

  always_comb begin
    lo_mask   = {WORD_BITS{1'b1}} << op.lo;
    hi_mask   = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - op.hi);
    mask      = lo_mask & hi_mask;
    free_bits = ~word & mask;
    pos       = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        pos = BIT_W'(i);
      end
    end
    res.new_word = op.op_clear ? (word & ~mask) : (word | mask);
    res.hit_any  = |(word & mask);
    res.free_any = |free_bits;
    res.free_pos = pos;
  end

endmodule

// ===== rtl/core/sector_bitmap_allocator.sv =====
// Sector bitmap allocator top level: command sequencer around the bitmap
// storage and the shared word unit. Depends on sba_pkg, sba_if, sba_bitmap_mem
// and sba_word_alu.
//
//   channel  direction  beat contents
//   in_ch    sink       command, sector_index, size_bytes
//   out_ch   source     bit_value, found, free_sector, range_error
//   cfg_*    write      search_start
//
// Set, clear and test go from the accepted beat through the read, work and done
// states to the result beat; a bad index or search start goes straight to done.
// A find reads one 64-sector bitmap word per cycle until a free bit or the last
// word; a run mark sets every word it touches. A new command is accepted
// whenever the sequencer is idle, even while a result beat waits. Reset clears
// the row valid bits at once, so the whole bitmap reads as free.
module sector_bitmap_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  sba_in_if.sink                    in_ch,
  sba_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [sba_pkg::IDX_W-1:0] cfg_data
);
  import sba_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_WORK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]         state_r;
  logic [1:0]         state_nxt;
  logic [IDX_W-1:0]   search_start_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [IDX_W-1:0]   first_r;
  logic [IDX_W-1:0]   last_r;
  logic [WADDR_W-1:0] addr_r;
  logic               res_bit_r;
  logic               res_found_r;
  logic [IDX_W-1:0]   res_free_r;
  logic               res_rerr_r;
  logic               out_valid_r;
  logic               out_bit_r;
  logic               out_found_r;
  logic [IDX_W-1:0]   out_free_r;
  logic               out_rerr_r;

  logic               in_acc;
  logic               out_free;
  logic               idx_oor;
  logic [RUN_W-1:0]   run_sum;
  logic               run_over;
  logic [IDX_W-1:0]   acc_first;
  logic [IDX_W-1:0]   acc_last;
  logic               acc_rerr;
  logic               acc_skip;

  logic               is_find;
  logic               last_word;
  logic               step;
  logic               rd_en;
  logic [WADDR_W-1:0] rd_addr;
  logic               wr_en;
  logic [WORD_BITS-1:0] rd_word;
  sba_alu_op_t        alu_op;
  sba_alu_res_t       alu_res;

  sba_bitmap_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (addr_r),
    .wr_data (alu_res.new_word),
    .rd_data (rd_word)
  );

  sba_word_alu u_alu (
    .word (rd_word),
    .op   (alu_op),
    .res  (alu_res)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    idx_oor  = 32'(in_ch.sector_index) >= SECTORS;
    run_sum  = RUN_W'(in_ch.sector_index) + RUN_W'(in_ch.size_bytes >> LOG_SB);
    run_over = 32'(run_sum) >= SECTORS;
    acc_first = in_ch.sector_index;
    acc_last  = in_ch.sector_index;
    acc_rerr  = 1'b0;
    acc_skip  = 1'b0;
    unique case (in_ch.command)
      CMD_SET, CMD_CLEAR, CMD_TEST: begin
        acc_rerr = idx_oor;
        acc_skip = idx_oor;
      end
      CMD_FIND0: begin
        acc_first = '0;
        acc_last  = LAST_SECTOR;
      end
      CMD_FINDS: begin
        acc_first = search_start_r;
        acc_last  = LAST_SECTOR;
        acc_rerr  = 32'(search_start_r) >= SECTORS;
        acc_skip  = acc_rerr;
      end
      CMD_RUN: begin
        acc_last = run_over ? LAST_SECTOR : run_sum[IDX_W-1:0];
        acc_rerr = idx_oor || run_over;
        acc_skip = idx_oor;
      end
      default: begin
        acc_skip = 1'b1;
      end
    endcase
  end

  always_comb begin
    is_find   = (cmd_r == CMD_FIND0) || (cmd_r == CMD_FINDS);
    last_word = (addr_r == last_r[BIT_W +: WADDR_W]);
    alu_op.op_clear = (cmd_r == CMD_CLEAR);
    alu_op.lo = (addr_r == first_r[BIT_W +: WADDR_W]) ? first_r[BIT_W-1:0] : '0;
    alu_op.hi = last_word ? last_r[BIT_W-1:0] : '1;
    step  = (state_r == ST_WORK) && !last_word &&
            ((cmd_r == CMD_RUN) || (is_find && !alu_res.free_any));
    wr_en = (state_r == ST_WORK) &&
            ((cmd_r == CMD_SET) || (cmd_r == CMD_CLEAR) || (cmd_r == CMD_RUN));
    rd_en   = (state_r == ST_READ) || step;
    rd_addr = (state_r == ST_READ) ? addr_r : addr_r + 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = acc_skip ? ST_DONE : ST_READ;
        end
      end
      ST_READ: state_nxt = ST_WORK;
      ST_WORK: state_nxt = step ? ST_WORK : ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      search_start_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        search_start_r <= cfg_data;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r       <= in_ch.command;
      first_r     <= acc_first;
      last_r      <= acc_last;
      addr_r      <= acc_first[BIT_W +: WADDR_W];
      res_bit_r   <= 1'b0;
      res_found_r <= 1'b0;
      res_free_r  <= '0;
      res_rerr_r  <= acc_rerr;
    end
    if (state_r == ST_WORK) begin
      if (cmd_r == CMD_TEST) begin
        res_bit_r <= alu_res.hit_any;
      end
      if (is_find && alu_res.free_any) begin
        res_found_r <= 1'b1;
        res_free_r  <= IDX_W'({addr_r, alu_res.free_pos});
      end
      if (step) begin
        addr_r <= addr_r + 1'b1;
      end
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_bit_r   <= res_bit_r;
      out_found_r <= res_found_r;
      out_free_r  <= res_free_r;
      out_rerr_r  <= res_rerr_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.bit_value   = out_bit_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.free_sector = out_free_r;
  assign out_ch.range_error = out_rerr_r;

  a_wr_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_WORK) && (cmd_r != CMD_TEST) && !is_find)
    else $error("bitmap written outside a modifying command");

  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("sequencer stayed idle after an accepted beat");

  a_found_no_rerr: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.found && out_ch.range_error))
    else $error("result reports both found and range error");

  a_found_no_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.found && out_ch.bit_value))
    else $error("result reports both found and a tested bit");

endmodule
